// ===== sv/fog_shade_grid_smoother_core_macros.svh =====
// Assertion macros shared by the shade smoother checker.
`ifndef FOG_SHADE_GRID_SMOOTHER_CORE_MACROS_SVH
`define FOG_SHADE_GRID_SMOOTHER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fsgs_pkg.sv =====
// Types, constants and helper functions for the fog shade grid smoother.
package fsgs_pkg;

  // Default patch size in tiles; the vertex grid is one larger in each dimension.
  localparam int PATCH_TILES_DEF = 16;

  localparam int COORD_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // One memory word holds the Q8.8 smoothed level above the shown whole level.
  localparam int LEVEL_W = 16;
  localparam int SHADE_W = 8;
  localparam int WORD_W  = LEVEL_W + SHADE_W;

  localparam logic [LEVEL_W-1:0] RESET_SMOOTH = 16'hFE00;
  localparam logic [SHADE_W-1:0] FULL_SHADE   = 8'd255;
  localparam logic [WORD_W-1:0]  RESET_WORD   = {RESET_SMOOTH, FULL_SHADE};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_MAP_WIDE     = 3'd2,
    CFG_MAP_HIGH     = 3'd3,
    CFG_BASE_OPACITY = 3'd4
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WRITE
  } fsgs_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] vertex_col;
    logic [COORD_W-1:0] vertex_row;
    logic               center_seen;
    logic [7:0]         neighbour_seen;
    logic [15:0]        decay_factor;
    logic               force_update;
    logic               frame_last;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [7:0]         shade_level;
    logic [7:0]         vertex_alpha;
    logic               level_changed;
    logic               frame_done;
    logic               frame_any_change;
    logic               patch_clear;
    logic               patch_dark;
  } result_t;

  // Target shade: zero when visible, else floor(255*(16-n)/16) for n visible neighbours.
  function automatic logic [SHADE_W-1:0] shade_target(input logic       center_seen,
                                                      input logic [7:0] nbrs);
    logic [3:0]  n;
    logic [12:0] scaled;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nbrs[i]);
    end
    scaled = 13'(FULL_SHADE) * 13'(5'd16 - {1'b0, n});
    return center_seen ? '0 : scaled[11:4];
  endfunction

endpackage

// ===== sv/fog_shade_grid_smoother_core.sv =====
// Each item is a read-modify-write of the level memory: the transfer captures the item and
// reads its entry, the compute step registers the target and the decayed gap, and the write
// step writes back and loads the output register once the output is free; a new item can
// be taken then. Reset: rst resets control state, configuration, frame flags and result_valid,
// then a clearing pass writes all (PATCH_TILES+1)^2 (289 by default) entries, item_stall high.
module fog_shade_grid_smoother_core #(
  parameter int PATCH_TILES = fsgs_pkg::PATCH_TILES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fsgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsgs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  fsgs_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output fsgs_pkg::result_t               result
);
  import fsgs_pkg::*;

  localparam int GRID_SIDE  = PATCH_TILES + 1;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(GRID_CELLS);

  // Configuration registers.
  logic [11:0] origin_x, origin_y;
  logic [12:0] map_wide, map_high;
  logic [8:0]  base_opacity;

  // Control state.
  fsgs_state_t       state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic              run_changed, run_all_zero, run_all_max;
  logic              clear_flag, dark_flag;

  // Item held through the update.
  item_t             item_q;
  logic [ADDR_W-1:0] addr_q;
  logic              in_range_q;
  logic              fwd_q;
  logic [WORD_W-1:0] fwd_word_q;

  // Registered results of the compute cycle.
  logic [SHADE_W-1:0] target_q;
  logic               above_q;
  logic [LEVEL_W-1:0] scaled_q;
  logic [SHADE_W-1:0] shown_q;
  logic               border_q;

  // Memory port signals.
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic              accept, out_free, commit;
  logic              item_in_range;
  logic [ADDR_W-1:0] item_addr;

  // Compute cycle signals.
  logic [WORD_W-1:0]  word_cur;
  logic [LEVEL_W-1:0] level_cur, goal, gap;
  logic [SHADE_W-1:0] target;
  logic               above;
  logic [31:0]        gap_prod;
  logic [12:0]        grid_x, grid_y;
  logic               border;

  // Write cycle signals.
  logic [LEVEL_W-1:0] goal_w, level_new;
  logic [SHADE_W-1:0] whole, alpha;
  logic               changed;
  logic [16:0]        alpha_prod;
  logic               run_changed_new, run_all_zero_new, run_all_max_new;

  fsgs_level_ram #(
    .DEPTH(GRID_CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(item_addr),
    .rdata(mem_rdata)
  );

  // Address decode of the incoming vertex.
  assign item_in_range = (int'(item.vertex_col) <= PATCH_TILES) &&
                         (int'(item.vertex_row) <= PATCH_TILES);
  assign item_addr = ADDR_W'(int'(item.vertex_row) * GRID_SIDE + int'(item.vertex_col));

  assign out_free = !result_valid || !result_stall;
  assign accept   = item_valid && !item_stall;
  assign commit   = (state == ST_WRITE) && out_free;

  // The level memory is read on every transfer.
  assign mem_re   = accept;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(GRID_CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = accept ? ST_CALC : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and memory write port.
  always_comb begin
    item_stall = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = {level_new, whole};
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = RESET_WORD;
      end
      ST_IDLE: begin
        item_stall = 1'b0;
      end
      ST_CALC: begin
        item_stall = 1'b1;
      end
      ST_WRITE: begin
        item_stall = !out_free;
        mem_we     = out_free && in_range_q;
      end
      default: item_stall = 1'b1;
    endcase
  end

  // State register and clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      map_wide     <= 13'd4096;
      map_high     <= 13'd4096;
      base_opacity <= 9'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:     origin_x     <= cfg_data[11:0];
        CFG_ORIGIN_Y:     origin_y     <= cfg_data[11:0];
        CFG_MAP_WIDE:     map_wide     <= cfg_data;
        CFG_MAP_HIGH:     map_high     <= cfg_data;
        CFG_BASE_OPACITY: base_opacity <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Capture of a transferred item; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q     <= item;
      addr_q     <= item_addr;
      in_range_q <= item_in_range;
      fwd_q      <= mem_we && (mem_waddr == item_addr);
      fwd_word_q <= mem_wdata;
    end
  end

  // Compute cycle: target, gap to the target and its decayed size, border test.
  assign word_cur  = fwd_q ? fwd_word_q : mem_rdata;
  assign level_cur = word_cur[WORD_W-1:SHADE_W];
  assign target    = shade_target(item_q.center_seen, item_q.neighbour_seen);
  assign goal      = {target, 8'h00};
  assign above     = level_cur > goal;
  assign gap       = above ? (level_cur - goal) : (goal - level_cur);
  assign gap_prod  = 32'(gap) * 32'(item_q.decay_factor);
  assign grid_x    = 13'(item_q.vertex_col) + 13'(origin_x);
  assign grid_y    = 13'(item_q.vertex_row) + 13'(origin_y);
  assign border    = (grid_x == '0) || (grid_y == '0) ||
                     (grid_x >= map_wide) || (grid_y >= map_high);

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      target_q <= target;
      above_q  <= above;
      scaled_q <= gap_prod[31:16];
      shown_q  <= word_cur[SHADE_W-1:0];
      border_q <= border;
    end
  end

  // Write cycle: new level from the target side it came from, alpha and frame flags.
  assign goal_w     = {target_q, 8'h00};
  assign level_new  = item_q.force_update ? goal_w :
                      (above_q ? (goal_w + scaled_q) : (goal_w - scaled_q));
  assign whole      = level_new[LEVEL_W-1:SHADE_W];
  assign changed    = item_q.force_update || (whole != shown_q);
  assign alpha_prod = 17'(whole) * 17'(base_opacity);
  assign alpha      = border_q ? FULL_SHADE :
                      (alpha_prod[16] ? FULL_SHADE : alpha_prod[15:8]);

  assign run_changed_new  = run_changed || (in_range_q && changed);
  assign run_all_zero_new = run_all_zero && (!in_range_q || (whole == '0));
  assign run_all_max_new  = run_all_max && (!in_range_q || (whole == FULL_SHADE));

  // Frame pass flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_changed  <= 1'b0;
      run_all_zero <= 1'b1;
      run_all_max  <= 1'b1;
      clear_flag   <= 1'b1;
      dark_flag    <= 1'b0;
    end else if (commit) begin
      if (item_q.frame_last) begin
        run_changed  <= 1'b0;
        run_all_zero <= 1'b1;
        run_all_max  <= 1'b1;
        if (run_changed_new) begin
          clear_flag <= run_all_zero_new;
          dark_flag  <= run_all_max_new;
        end
      end else begin
        run_changed  <= run_changed_new;
        run_all_zero <= run_all_zero_new;
        run_all_max  <= run_all_max_new;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.out_col          <= item_q.vertex_col;
      result.out_row          <= item_q.vertex_row;
      result.shade_level      <= in_range_q ? whole : '0;
      result.vertex_alpha     <= in_range_q ? alpha : '0;
      result.level_changed    <= in_range_q && changed;
      result.frame_done       <= item_q.frame_last;
      result.frame_any_change <= item_q.frame_last && run_changed_new;
      result.patch_clear      <= item_q.frame_last &&
                                 (run_changed_new ? run_all_zero_new : clear_flag);
      result.patch_dark       <= item_q.frame_last &&
                                 (run_changed_new ? run_all_max_new : dark_flag);
    end
  end

endmodule

// ===== sv/fsgs_level_ram.sv =====
// Single-port-write, single-port-read level memory with registered read data.
module fsgs_level_ram #(
  parameter  int DEPTH  = (fsgs_pkg::PATCH_TILES_DEF + 1) * (fsgs_pkg::PATCH_TILES_DEF + 1),
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [fsgs_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [fsgs_pkg::WORD_W-1:0] rdata
);
  import fsgs_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/fsgs_checker.sv =====
// Port-level checker for the fog shade grid smoother and its bind.
`include "fog_shade_grid_smoother_core_macros.svh"

module fsgs_checker #(
  parameter int PATCH_TILES = fsgs_pkg::PATCH_TILES_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input fsgs_pkg::result_t result
);
  import fsgs_pkg::*;

  // A stalled result stays offered unchanged.
  `FSGS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  // A vertex outside the patch carries no shade, alpha or change.
  `FSGS_ASSERT_NOW(a_out_of_range_zero, result_valid && ((int'(result.out_col) > PATCH_TILES) || (int'(result.out_row) > PATCH_TILES)), (result.shade_level == '0) && (result.vertex_alpha == '0) && !result.level_changed, "out-of-range vertex reported a level")

  // Frame flags appear only at frame end.
  `FSGS_ASSERT_NOW(a_frame_fields_idle, result_valid && !result.frame_done, !result.frame_any_change && !result.patch_clear && !result.patch_dark, "frame flags set off frame end")

  // A patch cannot be both fully clear and fully dark.
  `FSGS_ASSERT_NOW(a_clear_dark_exclusive, result_valid && result.frame_done, !(result.patch_clear && result.patch_dark), "patch reported clear and dark together")

endmodule

bind fog_shade_grid_smoother_core fsgs_checker #(.PATCH_TILES(PATCH_TILES)) u_fsgs_checker (.*);
